// ----- hdl/emt_pkg.sv -----
// Shared constants and types for the multi-turn encoder tracker.
`default_nettype none

package emt_pkg;

    localparam int TURN_BITS_DEF = 32;
    localparam int ANGLE_W       = 14;
    localparam int HALF_TURN     = 8192;
    localparam int TICK_W        = 32;
    localparam int VEL_W         = 32;
    localparam int TURN_OUT_W    = 32;
    localparam int POS_OUT_W     = 46;
    localparam int LEVEL_W       = 8;

    // Scaling by 1000 is done as x*1024 - x*16 - x*8.
    localparam int SCALE_SH_HI   = 10;
    localparam int SCALE_SH_MID  = 4;
    localparam int SCALE_SH_LO   = 3;
    localparam int SCALE_GUARD   = SCALE_SH_HI + 1;

    localparam int CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_DEC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERR_THR = 2'd2;

    localparam logic [LEVEL_W-1:0] ERR_INC_RST = 8'd10;
    localparam logic [LEVEL_W-1:0] ERR_DEC_RST = 8'd1;
    localparam logic [LEVEL_W-1:0] ERR_THR_RST = 8'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'hFF;

    localparam int LO_NOMAG_BIT  = 1;
    localparam int LO_PARITY_BIT = 0;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_OFFLINE = 2'd1,
        ST_ERROR   = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/emt_velocity.sv -----
// Velocity unit: position difference, scaling by 1000 and serial division on one shared adder.
`default_nettype none

module emt_velocity #(
    parameter int POS_W = emt_pkg::TURN_BITS_DEF + emt_pkg::ANGLE_W
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [POS_W-1:0]           i_pos,
    input  wire logic [POS_W-1:0]           i_prev_pos,
    input  wire logic [emt_pkg::TICK_W-1:0] i_dt,
    output logic                            o_done,
    output logic [emt_pkg::VEL_W-1:0]       o_velocity
);
    import emt_pkg::*;

    localparam int ACC_W = POS_W + SCALE_GUARD;
    localparam int Q_W   = VEL_W;
    localparam int CNT_W = $clog2(Q_W);

    localparam logic [VEL_W-1:0] NEG_LIM = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [VEL_W-1:0] POS_LIM = {1'b0, {(VEL_W-1){1'b1}}};

    typedef enum logic [2:0] {
        V_IDLE, V_DIFF, V_ABS, V_MUL1, V_MUL2, V_OVF, V_DIV, V_SAT
    } t_vstate;

    t_vstate            r_state;
    logic [ACC_W-1:0]   r_acc;
    logic [POS_W:0]     r_mag;
    logic               r_neg;
    logic               r_ovf;
    logic [TICK_W-1:0]  r_dt;
    logic [TICK_W-1:0]  r_rem;
    logic [Q_W-1:0]     r_quo;
    logic [CNT_W-1:0]   r_cnt;

    logic [ACC_W-1:0]   w_a;
    logic [ACC_W-1:0]   w_b;
    logic               w_sub;
    logic [ACC_W:0]     w_sum;
    logic               w_carry;
    logic [VEL_W-1:0]   w_clamp;
    logic [ACC_W-1:0]   w_mag_ext;
    logic [ACC_W-1:0]   w_hi_ext;

    assign w_mag_ext = ACC_W'(r_mag);
    assign w_hi_ext  = ACC_W'(r_acc[ACC_W-1:Q_W]);

    // Magnitude limit: the negative side reaches one count further.
    always_comb begin
        if (r_neg) begin
            w_clamp = (r_ovf || (r_quo[Q_W-1] && (r_quo[Q_W-2:0] != '0))) ? NEG_LIM : r_quo;
        end else begin
            w_clamp = (r_ovf || r_quo[Q_W-1]) ? POS_LIM : r_quo;
        end
    end

    // Operand selection for the one adder.
    always_comb begin
        w_a   = '0;
        w_b   = '0;
        w_sub = 1'b0;
        case (r_state)
            V_DIFF: begin
                w_a   = ACC_W'($signed(i_pos));
                w_b   = ACC_W'($signed(i_prev_pos));
                w_sub = 1'b1;
            end
            V_ABS: begin
                w_a   = r_neg ? '0 : r_acc;
                w_b   = r_neg ? r_acc : '0;
                w_sub = r_neg;
            end
            V_MUL1: begin
                w_a   = w_mag_ext << SCALE_SH_HI;
                w_b   = w_mag_ext << SCALE_SH_MID;
                w_sub = 1'b1;
            end
            V_MUL2: begin
                w_a   = r_acc;
                w_b   = w_mag_ext << SCALE_SH_LO;
                w_sub = 1'b1;
            end
            V_OVF: begin
                w_a   = w_hi_ext;
                w_b   = ACC_W'(r_dt);
                w_sub = 1'b1;
            end
            V_DIV: begin
                w_a   = ACC_W'({r_rem, r_quo[Q_W-1]});
                w_b   = ACC_W'(r_dt);
                w_sub = 1'b1;
            end
            V_SAT: begin
                w_a   = r_neg ? '0 : ACC_W'(w_clamp);
                w_b   = r_neg ? ACC_W'(w_clamp) : '0;
                w_sub = r_neg;
            end
            default: begin
                w_a   = '0;
                w_b   = '0;
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum   = {1'b0, w_a} + {1'b0, w_b ^ {ACC_W{w_sub}}} + (ACC_W+1)'(w_sub);
    assign w_carry = w_sum[ACC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                V_IDLE: begin
                    if (i_start) begin
                        r_dt    <= i_dt;
                        r_state <= V_DIFF;
                    end
                end
                V_DIFF: begin
                    r_acc   <= w_sum[ACC_W-1:0];
                    r_neg   <= w_sum[ACC_W-1];
                    r_state <= V_ABS;
                end
                V_ABS: begin
                    r_mag   <= w_sum[POS_W:0];
                    r_state <= V_MUL1;
                end
                V_MUL1: begin
                    r_acc   <= w_sum[ACC_W-1:0];
                    r_state <= V_MUL2;
                end
                V_MUL2: begin
                    r_acc   <= w_sum[ACC_W-1:0];
                    r_state <= V_OVF;
                end
                V_OVF: begin
                    // A high part not below the divisor means the quotient does not fit.
                    r_ovf   <= w_carry;
                    r_rem   <= w_hi_ext[TICK_W-1:0];
                    r_quo   <= r_acc[Q_W-1:0];
                    r_cnt   <= '0;
                    r_state <= w_carry ? V_SAT : V_DIV;
                end
                V_DIV: begin
                    if (w_carry) begin
                        r_rem <= w_sum[TICK_W-1:0];
                        r_quo <= {r_quo[Q_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[TICK_W-2:0], r_quo[Q_W-1]};
                        r_quo <= {r_quo[Q_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(Q_W - 1)) begin
                        r_state <= V_SAT;
                    end
                end
                V_SAT: begin
                    o_velocity <= w_sum[VEL_W-1:0];
                    o_done     <= 1'b1;
                    r_state    <= V_IDLE;
                end
                default: begin
                    r_state <= V_IDLE;
                end
            endcase
        end
    end

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == V_IDLE)
        else $error("velocity unit started while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == V_DIV |-> r_rem < r_dt)
        else $error("division remainder not below divisor");

    a_done_after_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == V_SAT)
        else $error("done raised outside the final step");

endmodule

`default_nettype wire

// ----- hdl/encoder_multiturn_tracker.sv -----
// Multi-turn angle, position, velocity and status tracking for a magnetic encoder.
// Sequence: accept, calculate, velocity unit and final output register when velocity is
// computed (the velocity unit skips division when the quotient saturates early); the
// velocity unit is skipped when velocity is held or no magnet. A new item is accepted only
// after the last result is registered; division takes 32 one-bit steps of the shared adder.
// Reset: synchronous, active low; clears tracking, error level and status, restores registers.
`default_nettype none

module encoder_multiturn_tracker #(
    parameter int TURN_BITS = emt_pkg::TURN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,

    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [7:0]                        i_angle_high_byte,
    input  wire logic [7:0]                        i_angle_low_byte,
    input  wire logic [emt_pkg::TICK_W-1:0]        i_now_ms,

    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [emt_pkg::ANGLE_W-1:0]            o_angle_counts,
    output logic signed [emt_pkg::TURN_OUT_W-1:0]  o_turn_count,
    output logic signed [emt_pkg::POS_OUT_W-1:0]   o_position_counts,
    output logic signed [emt_pkg::VEL_W-1:0]       o_velocity_cps,
    output logic [1:0]                             o_device_status,
    output logic [emt_pkg::LEVEL_W-1:0]            o_error_level,
    output logic                                   o_parity_good,

    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [emt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data
);
    import emt_pkg::*;

    localparam int POS_W = TURN_BITS + ANGLE_W;
    localparam logic signed [ANGLE_W:0] HALF_POS = (ANGLE_W+1)'(HALF_TURN);
    localparam logic signed [ANGLE_W:0] HALF_NEG = -HALF_POS;

    typedef enum logic [2:0] {
        S_IDLE, S_CALC, S_VSTART, S_VWAIT, S_FIN
    } t_state;

    t_state                r_state;
    logic [7:0]            r_hi;
    logic [7:0]            r_lo;
    logic [TICK_W-1:0]     r_now;
    logic [TICK_W-1:0]     r_dt;
    logic [TICK_W-1:0]     r_prev_tick;
    logic [ANGLE_W-1:0]    r_prev_angle;
    logic [ANGLE_W-1:0]    r_angle_res;
    logic [TURN_BITS-1:0]  r_turns;
    logic [POS_W-1:0]      r_pos;
    logic [POS_W-1:0]      r_prev_pos;
    logic [VEL_W-1:0]      r_vel;
    logic [LEVEL_W-1:0]    r_lvl;
    logic [LEVEL_W-1:0]    r_err_inc;
    logic [LEVEL_W-1:0]    r_err_dec;
    logic [LEVEL_W-1:0]    r_err_thr;
    t_status               r_status;
    logic                  r_pgood;

    logic [ANGLE_W-1:0]    w_angle;
    logic                  w_no_mag;
    logic signed [ANGLE_W:0] w_delta;
    logic [TURN_BITS-1:0]  w_turns;
    logic [TICK_W-1:0]     w_dt;
    logic                  w_pgood;
    logic [LEVEL_W:0]      w_lvl_up;
    logic [LEVEL_W-1:0]    w_lvl;
    logic                  w_in_acc;
    logic                  w_out_free;
    logic                  w_vel_start;
    logic                  w_vel_done;
    logic [VEL_W-1:0]      w_vel;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !o_out_valid || !i_out_stall;
    assign w_vel_start = (r_state == S_VSTART);

    assign w_angle  = {r_hi, r_lo[7:2]};
    assign w_no_mag = r_lo[LO_NOMAG_BIT];
    assign w_delta  = $signed({1'b0, w_angle}) - $signed({1'b0, r_prev_angle});
    assign w_dt     = r_now - r_prev_tick;
    assign w_pgood  = (^w_angle) == r_lo[LO_PARITY_BIT];
    assign w_lvl_up = {1'b0, r_lvl} + {1'b0, r_err_inc};

    always_comb begin
        if (w_delta > HALF_POS) begin
            w_turns = r_turns - TURN_BITS'(1);
        end else if (w_delta < HALF_NEG) begin
            w_turns = r_turns + TURN_BITS'(1);
        end else begin
            w_turns = r_turns;
        end
    end

    // Leaky error level: saturates upward, floors at zero.
    always_comb begin
        if (!w_pgood) begin
            w_lvl = w_lvl_up[LEVEL_W] ? LEVEL_MAX : w_lvl_up[LEVEL_W-1:0];
        end else begin
            w_lvl = (r_lvl > r_err_dec) ? r_lvl - r_err_dec : '0;
        end
    end

    emt_velocity #(
        .POS_W (POS_W)
    ) u_velocity (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_vel_start),
        .i_pos      (r_pos),
        .i_prev_pos (r_prev_pos),
        .i_dt       (r_dt),
        .o_done     (w_vel_done),
        .o_velocity (w_vel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_tick  <= '0;
            r_prev_angle <= '0;
            r_turns      <= '0;
            r_pos        <= '0;
            r_prev_pos   <= '0;
            r_vel        <= '0;
            r_lvl        <= '0;
            r_status     <= ST_RUNNING;
            r_err_inc    <= ERR_INC_RST;
            r_err_dec    <= ERR_DEC_RST;
            r_err_thr    <= ERR_THR_RST;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ERR_INC: r_err_inc <= i_cfg_data;
                    CFG_ERR_DEC: r_err_dec <= i_cfg_data;
                    CFG_ERR_THR: r_err_thr <= i_cfg_data;
                    default: ;
                endcase
            end

            // In the final state the result register is reloaded below instead.
            if (o_out_valid && !i_out_stall && r_state != S_FIN) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_hi    <= i_angle_high_byte;
                        r_lo    <= i_angle_low_byte;
                        r_now   <= i_now_ms;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_prev_tick <= r_now;
                    r_dt        <= w_dt;
                    if (w_no_mag) begin
                        // Without a magnet all tracking restarts from zero.
                        r_prev_angle <= '0;
                        r_turns      <= '0;
                        r_pos        <= '0;
                        r_vel        <= '0;
                        r_angle_res  <= '0;
                        r_pgood      <= 1'b0;
                        r_status     <= ST_OFFLINE;
                        r_state      <= S_FIN;
                    end else begin
                        r_prev_angle <= w_angle;
                        r_turns      <= w_turns;
                        r_pos        <= {w_turns, w_angle};
                        r_angle_res  <= w_angle;
                        r_pgood      <= w_pgood;
                        r_lvl        <= w_lvl;
                        r_status     <= (w_lvl > r_err_thr) ? ST_ERROR : ST_RUNNING;
                        r_state      <= (w_dt != '0) ? S_VSTART : S_FIN;
                    end
                end
                S_VSTART: begin
                    r_state <= S_VWAIT;
                end
                S_VWAIT: begin
                    if (w_vel_done) begin
                        r_vel   <= w_vel;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_prev_pos        <= r_pos;
                        o_angle_counts    <= r_angle_res;
                        o_turn_count      <= TURN_OUT_W'(r_turns);
                        o_position_counts <= POS_OUT_W'($signed(r_pos));
                        o_velocity_cps    <= r_vel;
                        o_device_status   <= r_status;
                        o_error_level     <= r_lvl;
                        o_parity_good     <= r_pgood;
                        o_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_vel_needs_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vel_start |-> r_dt != '0)
        else $error("velocity started with no elapsed time");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled while a transaction is in progress");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vel_done |-> r_state == S_VWAIT)
        else $error("velocity result arrived outside the wait state");

    a_offline_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_device_status == ST_OFFLINE)
            |-> (o_position_counts == '0 && o_velocity_cps == '0 && o_turn_count == '0))
        else $error("offline result carries tracking data");

endmodule

`default_nettype wire

// ----- dv/encoder_multiturn_tracker_test.sv -----
// Self-checking testbench for the multi-turn encoder tracker: predicted results against the block.
`timescale 1ns / 100ps

module encoder_multiturn_tracker_test;
    import emt_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int PRINT_CAP    = 40;
    localparam int HOLD_CYCLES  = 1200;
    // Index 3 decodes to no register and must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [31:0] tick;
    } t_sample;

    typedef struct packed {
        logic [ANGLE_W-1:0]    angle;
        logic [TURN_OUT_W-1:0] turns;
        logic [POS_OUT_W-1:0]  pos;
        logic [VEL_W-1:0]      vel;
        t_status               status;
        logic [LEVEL_W-1:0]    level;
        logic                  parity_ok;
    } t_track_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [7:0]                   i_angle_high_byte = 8'd0;
    logic [7:0]                   i_angle_low_byte = 8'd0;
    logic [TICK_W-1:0]            i_now_ms = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [ANGLE_W-1:0]           o_angle_counts;
    logic signed [TURN_OUT_W-1:0] o_turn_count;
    logic signed [POS_OUT_W-1:0]  o_position_counts;
    logic signed [VEL_W-1:0]      o_velocity_cps;
    logic [1:0]                   o_device_status;
    logic [LEVEL_W-1:0]           o_error_level;
    logic                         o_parity_good;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [7:0]                   i_cfg_data = 8'd0;

    encoder_multiturn_tracker u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_angle_high_byte (i_angle_high_byte),
        .i_angle_low_byte  (i_angle_low_byte),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_angle_counts    (o_angle_counts),
        .o_turn_count      (o_turn_count),
        .o_position_counts (o_position_counts),
        .o_velocity_cps    (o_velocity_cps),
        .o_device_status   (o_device_status),
        .o_error_level     (o_error_level),
        .o_parity_good     (o_parity_good),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Tracker state as the block should hold it, and its registers.
    logic [ANGLE_W-1:0]   tk_prev_angle = '0;
    logic [31:0]          tk_turns = '0;
    logic [45:0]          tk_prev_pos = '0;
    logic [31:0]          tk_prev_tick = '0;
    logic [31:0]          tk_vel = '0;
    logic [LEVEL_W-1:0]   tk_level = '0;
    t_status              tk_status = ST_RUNNING;
    logic [7:0]           cf_inc = ERR_INC_RST;
    logic [7:0]           cf_dec = ERR_DEC_RST;
    logic [7:0]           cf_thr = ERR_THR_RST;

    t_sample              pending_samples[$];
    t_track_result        expected_tracks[$];

    bit                   send_idle = 1'b0;
    bit                   recv_idle = 1'b0;
    bit                   want_hold = 1'b0;
    bit                   hold_done = 1'b0;
    bit                   in_taken = 1'b0;
    int                   send_gap = 0;
    int                   stall_left = 0;
    int                   hold_left = 0;

    int                   gen_angle = 0;
    int                   gen_dir = 1;
    logic [31:0]          gen_tick = 32'h9000_0000;

    int                   n_cycles = 0;
    int                   n_fail = 0;
    int                   n_samples = 0;
    int                   n_results = 0;
    int                   n_blocked = 0;
    int                   n_crossings = 0;
    int                   n_nomag = 0;
    int                   n_parity_bad = 0;
    int                   n_err_status = 0;
    int                   n_held = 0;

    function automatic t_track_result track_sample(input logic [7:0] hi, input logic [7:0] lo,
                                                   input logic [31:0] now);
        t_track_result r;
        logic [ANGLE_W-1:0] ang;
        logic [31:0] dt;
        int delta;
        logic [45:0] pos;
        longint dpos;
        logic [63:0] mag;
        logic [63:0] spd;
        logic [8:0] sum;
        logic ok;
        ang = {hi, lo[7:2]};
        dt = now - tk_prev_tick;
        ok = 1'b0;
        delta = int'({18'd0, ang}) - int'({18'd0, tk_prev_angle});
        if (delta > HALF_TURN) begin
            tk_turns = tk_turns - 1;
            n_crossings++;
        end else if (delta < -HALF_TURN) begin
            tk_turns = tk_turns + 1;
            n_crossings++;
        end
        pos = {tk_turns, ang};
        if (dt != 0) begin
            dpos = longint'($signed(pos)) - longint'($signed(tk_prev_pos));
            mag = (dpos < 0) ? 64'(-dpos) : 64'(dpos);
            spd = mag * 64'd1000 / {32'd0, dt};
            if (dpos < 0) begin
                tk_vel = (spd > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - spd);
            end else begin
                tk_vel = (spd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : spd[31:0];
            end
        end else begin
            n_held++;
        end
        tk_prev_angle = ang;
        tk_prev_pos = pos;
        tk_prev_tick = now;

        if (lo[LO_NOMAG_BIT]) begin
            // Losing the magnet wipes the tracking but leaves the error level alone.
            tk_status = ST_OFFLINE;
            tk_prev_angle = '0;
            tk_turns = '0;
            tk_prev_pos = '0;
            tk_vel = '0;
            ang = '0;
            pos = '0;
            n_nomag++;
        end else begin
            if (tk_status == ST_OFFLINE) tk_status = ST_RUNNING;
            ok = ((^ang) == lo[LO_PARITY_BIT]);
            if (!ok) begin
                sum = {1'b0, tk_level} + {1'b0, cf_inc};
                tk_level = sum[8] ? LEVEL_MAX : sum[7:0];
                n_parity_bad++;
            end else begin
                tk_level = (tk_level > cf_dec) ? tk_level - cf_dec : '0;
            end
            if (tk_level > cf_thr) tk_status = ST_ERROR;
            else if (tk_status == ST_ERROR) tk_status = ST_RUNNING;
        end
        if (tk_status == ST_ERROR) n_err_status++;

        r.angle = ang;
        r.turns = tk_turns;
        r.pos = pos;
        r.vel = tk_vel;
        r.status = tk_status;
        r.level = tk_level;
        r.parity_ok = ok;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(16, 80);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (n_fail < PRINT_CAP) $display("MISMATCH at result %0d: %s", n_results, msg);
        n_fail++;
    endtask

    task automatic queue_angle(input logic [13:0] ang, input bit nomag, input bit bad,
                               input logic [31:0] tick);
        t_sample s;
        s.hi = ang[13:6];
        s.lo = {ang[5:0], nomag, (^ang) ^ bad};
        s.tick = tick;
        pending_samples.push_back(s);
    endtask

    // Mostly a rotating shaft with a steady clock, with noise samples mixed in.
    task automatic queue_random(input int count, input int bad_pct);
        t_sample s;
        int step;
        int pick;
        bit nomag;
        bit bad;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                s.hi = 8'($urandom);
                s.lo = 8'($urandom);
                s.tick = $urandom;
                pending_samples.push_back(s);
            end else begin
                if ($urandom_range(0, 24) == 0) gen_dir = -gen_dir;
                pick = $urandom_range(0, 99);
                if (pick < 70) step = $urandom_range(0, 400);
                else if (pick < 95) step = $urandom_range(401, HALF_TURN - 1);
                else if (pick < 98) step = HALF_TURN;
                else step = $urandom_range(HALF_TURN + 1, 16383);
                gen_angle = (gen_angle + gen_dir * step) & 16'h3FFF;
                pick = $urandom_range(0, 99);
                if (pick < 75) gen_tick += $urandom_range(1, 5);
                else if (pick < 88) gen_tick += $urandom_range(6, 2000);
                else if (pick < 94) gen_tick = 32'hFFFF_FFFF - $urandom_range(0, 40);
                else if (pick < 97) gen_tick = $urandom;
                nomag = ($urandom_range(0, 99) < 3);
                bad = ($urandom_range(0, 99) < bad_pct);
                queue_angle(14'(gen_angle), nomag, bad, gen_tick);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ERR_INC: cf_inc = val;
            CFG_ERR_DEC: cf_dec = val;
            CFG_ERR_THR: cf_thr = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] inc, input logic [7:0] dec,
                              input logic [7:0] thr);
        write_reg(CFG_ERR_INC, inc);
        write_reg(CFG_ERR_DEC, dec);
        write_reg(CFG_ERR_THR, thr);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || i_in_valid || expected_tracks.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender: a new sample goes out only once the previous one has been taken by the block.
    always @(negedge i_clk) begin : drive_samples
        t_sample nxt;
        if (!i_in_valid || in_taken) begin
            in_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                nxt = pending_samples.pop_front();
                i_angle_high_byte <= nxt.hi;
                i_angle_low_byte <= nxt.lo;
                i_now_ms <= nxt.tick;
                i_in_valid <= 1'b1;
                send_gap = send_idle ? pick_gap() : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, including one long hold-off that fills the block up.
    always @(negedge i_clk) begin : drive_stall
        if (want_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = recv_idle ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_track_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (expected_tracks.size() == 0) begin
                flag_mismatch("result transaction with nothing expected");
            end else begin
                want = expected_tracks.pop_front();
                if (o_angle_counts !== want.angle)
                    flag_mismatch($sformatf("angle_counts got %0d want %0d",
                                            o_angle_counts, want.angle));
                if (o_turn_count !== want.turns)
                    flag_mismatch($sformatf("turn_count got %0d want %0d",
                                            o_turn_count, $signed(want.turns)));
                if (o_position_counts !== want.pos)
                    flag_mismatch($sformatf("position_counts got %0d want %0d",
                                            o_position_counts, $signed(want.pos)));
                if (o_velocity_cps !== want.vel)
                    flag_mismatch($sformatf("velocity_cps got %0d want %0d",
                                            o_velocity_cps, $signed(want.vel)));
                if (o_device_status !== want.status)
                    flag_mismatch($sformatf("device_status got %0d want %0d",
                                            o_device_status, want.status));
                if (o_error_level !== want.level)
                    flag_mismatch($sformatf("error_level got %0d want %0d",
                                            o_error_level, want.level));
                if (o_parity_good !== want.parity_ok)
                    flag_mismatch($sformatf("parity_good got %0b want %0b",
                                            o_parity_good, want.parity_ok));
            end
        end
        if (i_rst_n && i_in_valid) begin
            if (o_in_stall) begin
                n_blocked++;
            end else begin
                expected_tracks.push_back(track_sample(i_angle_high_byte, i_angle_low_byte,
                                                       i_now_ms));
                in_taken = 1'b1;
                n_samples++;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     n_cycles, expected_tracks.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: wrap-around of the angle in both directions and the
        // half-turn boundary, held velocity, a parity fault, loss of magnet and tick wrap.
        send_idle = 1'b1;
        recv_idle = 1'b1;
        queue_angle(14'd0, 1'b0, 1'b0, 32'd0);
        queue_angle(14'd16383, 1'b0, 1'b0, 32'd1);
        queue_angle(14'd0, 1'b0, 1'b0, 32'd3);
        queue_angle(14'd8192, 1'b0, 1'b0, 32'd3);
        queue_angle(14'd0, 1'b0, 1'b0, 32'd5);
        queue_angle(14'd8193, 1'b0, 1'b0, 32'd6);
        queue_angle(14'd0, 1'b0, 1'b0, 32'd7);
        queue_angle(14'd5000, 1'b0, 1'b1, 32'd8);
        pending_samples.push_back('{8'hFF, 8'hFF, 32'd9});
        queue_angle(14'd100, 1'b0, 1'b0, 32'd9);
        queue_angle(14'd3000, 1'b0, 1'b0, 32'hFFFF_FFF0);
        queue_angle(14'd2000, 1'b0, 1'b0, 32'd5);
        pending_samples.push_back('{8'h00, 8'h00, 32'hFFFF_FFFF});
        queue_angle(14'd16383, 1'b0, 1'b1, 32'h8000_0000);
        wait_idle();

        // Saturating error level, a zero decrement and a zero threshold.
        set_config(8'd255, 8'd0, 8'd0);
        write_reg(CFG_IDX_SPARE, 8'd7);
        queue_angle(14'd1234, 1'b0, 1'b1, 32'h8000_0001);
        queue_angle(14'd1300, 1'b0, 1'b0, 32'h8000_0002);
        queue_angle(14'd0, 1'b1, 1'b1, 32'h8000_0003);
        queue_angle(14'd50, 1'b0, 1'b0, 32'h8000_0004);
        wait_idle();

        // A full-scale threshold never trips, even with the level pinned at its top.
        set_config(8'd255, 8'd255, 8'd255);
        queue_angle(14'd60, 1'b0, 1'b0, 32'h8000_0005);
        queue_angle(14'd70, 1'b0, 1'b1, 32'h8000_0006);
        queue_angle(14'd80, 1'b0, 1'b0, 32'h8000_0007);
        wait_idle();

        set_config(ERR_INC_RST, ERR_DEC_RST, ERR_THR_RST);
        queue_random(250, 4);
        wait_idle();

        set_config(8'd1, 8'd1, 8'd0);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        queue_random(250, 10);
        wait_idle();

        set_config(8'd40, 8'd3, 8'd60);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        queue_random(250, 15);
        want_hold = 1'b1;
        wait_idle();

        set_config(8'd0, 8'd255, 8'd255);
        send_idle = 1'b0;
        queue_random(250, 20);
        wait_idle();

        set_config(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)),
                   8'($urandom_range(1, 254)));
        send_idle = 1'b1;
        recv_idle = 1'b0;
        queue_random(250, 8);
        wait_idle();

        repeat (60) @(posedge i_clk);
        $display("Checked %0d results from %0d samples in %0d cycles; input held off %0d cycles.",
                 n_results, n_samples, n_cycles, n_blocked);
        $display("Seen: %0d turn crossings, %0d no-magnet samples, %0d parity faults, %0d %s",
                 n_crossings, n_nomag, n_parity_bad, n_err_status,
                 $sformatf("error-status results, %0d samples with no elapsed time.", n_held));
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
